/* design/e2q_pkg.sv */
// Shared types, constants and fixed-point helpers for the Euler angle to quaternion block.
// Used by the polynomial cell, the sine/cosine unit and the top level.
// No dependencies.
package e2q_pkg;

	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [61:0] HALF_Q30 = 62'h2000_0000;
	localparam logic [63:0] PI4_Q32  = 64'hC90F_DAA2;

	// divisors of the Taylor steps, innermost first
	localparam int SIN_DIV [3] = '{42, 20, 6};
	localparam int COS_DIV [4] = '{56, 30, 12, 2};

	// pipeline depth of the sine/cosine unit and of the whole block
	localparam int SC_LAT     = 12;
	localparam int LAT        = SC_LAT + 5;
	localparam int FIFO_DEPTH = 32;
	localparam int FIFO_AW    = 5;

	typedef struct packed {
		logic        neg;
		logic [30:0] mag;
	} trig_t;

	typedef struct packed {
		logic [1:0] quad;
		logic       fold;
	} octant_t;

	// round a Q2.60 magnitude product to Q1.30, half up
	function automatic logic [30:0] rnd_q30(input logic [61:0] p);
		logic [61:0] s;
		s = p + HALF_Q30;
		return s[60:30];
	endfunction

	function automatic logic [30:0] mulr_q30(input logic [30:0] a, input logic [30:0] b);
		return rnd_q30(62'(a) * 62'(b));
	endfunction

endpackage

/* design/e2q_ifs.sv */
// Handshake channels of the Euler angle to quaternion block: angles in,
// quaternion out, threshold register write. No dependencies.
interface e2q_angle_if #(parameter int ANGLE_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] roll_angle;
	logic signed [ANGLE_BITS-1:0] pitch_angle;
	logic signed [ANGLE_BITS-1:0] yaw_angle;
	modport source(output valid, roll_angle, pitch_angle, yaw_angle, input ready);
	modport sink(input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface e2q_quat_if #(parameter int OUT_BITS = 16);
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] quat_w;
	logic signed [OUT_BITS-1:0] quat_x;
	logic signed [OUT_BITS-1:0] quat_y;
	logic signed [OUT_BITS-1:0] quat_z;
	modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface e2q_cfg_if;
	logic        valid;
	logic        ready;
	logic [14:0] snap_threshold;
	modport source(output valid, snap_threshold, input ready);
	modport sink(input valid, snap_threshold, output ready);
endinterface

/* design/e2q_poly_cell.sv */
// One Horner step of the sine/cosine series: t_o = 1 - (x2 * t) / D, two stages.
// Depends on e2q_pkg.
module e2q_poly_cell import e2q_pkg::*; #(
	parameter int D      = 2,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic [29:0]       x2,
	input  logic [30:0]       t,
	input  logic [SIDE_W-1:0] side,
	output logic [29:0]       x2_o,
	output logic [30:0]       t_o,
	output logic [SIDE_W-1:0] side_o
);

	// exact reciprocal for dividends below 2^31
	localparam int          L   = $clog2(D);
	localparam logic [63:0] RCP = ((64'd1 << (31 + L)) + 64'(D) - 64'd1) / D;

	logic [29:0]       prod_s1;
	logic [29:0]       x2_s1;
	logic [SIDE_W-1:0] side_s1;
	logic [63:0]       qp;

	assign qp = 64'(prod_s1) * RCP;

	always_ff @(posedge clk) begin
		prod_s1 <= 30'(mulr_q30({1'b0, x2}, t));
		x2_s1   <= x2;
		side_s1 <= side;
		t_o     <= ONE_Q30 - 31'(qp >> (31 + L));
		x2_o    <= x2_s1;
		side_o  <= side_s1;
	end

endmodule

/* design/e2q_sincos.sv */
// Sine and cosine of a half angle in Q1.30, snapped to zero below the threshold.
// Fixed 12-stage pipeline. Depends on e2q_pkg and e2q_poly_cell.
module e2q_sincos import e2q_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter bit NEGATE     = 1'b0
) (
	input  logic                  clk,
	input  logic [ANGLE_BITS-1:0] angle,
	input  logic [14:0]           thr,
	output trig_t                 sin_o,
	output trig_t                 cos_o
);

	logic [32:0] a33;
	logic [32:0] phase;
	logic [30:0] r;
	logic        fold;
	logic [63:0] xp;

	logic [30:0] rr_s1;
	octant_t     oct_s1, oct_s2, oct_s3;
	logic [29:0] x_s2, x_s3, x2_s3;

	always_comb begin
		a33 = {{(33 - ANGLE_BITS){angle[ANGLE_BITS-1]}}, angle};
		if (NEGATE) begin
			a33 = 33'd0 - a33;
		end
		phase = a33 << (32 - ANGLE_BITS);
		r     = phase[30:0];
		fold  = r > 31'h4000_0000;
	end

	assign xp = 64'(rr_s1) * PI4_Q32 + 64'h8000_0000;

	always_ff @(posedge clk) begin
		rr_s1  <= fold ? 31'(32'h8000_0000 - 32'(r)) : r;
		oct_s1 <= '{quad: phase[32:31], fold: fold};
		x_s2   <= xp[61:32];
		oct_s2 <= oct_s1;
		x_s3   <= x_s2;
		x2_s3  <= 30'(mulr_q30({1'b0, x_s2}, {1'b0, x_s2}));
		oct_s3 <= oct_s2;
	end

	// sine chain carries x along, cosine chain carries the octant
	logic [29:0] sx2 [4];
	logic [30:0] st  [4];
	logic [29:0] sx  [4];
	logic [29:0] cx2 [5];
	logic [30:0] ct  [5];
	octant_t     co  [5];

	assign sx2[0] = x2_s3;
	assign st[0]  = ONE_Q30;
	assign sx[0]  = x_s3;
	assign cx2[0] = x2_s3;
	assign ct[0]  = ONE_Q30;
	assign co[0]  = oct_s3;

	for (genvar i = 0; i < 3; i++) begin : g_sin
		e2q_poly_cell #(.D(SIN_DIV[i]), .SIDE_W(30)) u_cell (
			.clk, .x2(sx2[i]), .t(st[i]), .side(sx[i]),
			.x2_o(sx2[i+1]), .t_o(st[i+1]), .side_o(sx[i+1])
		);
	end

	for (genvar i = 0; i < 4; i++) begin : g_cos
		e2q_poly_cell #(.D(COS_DIV[i]), .SIDE_W(3)) u_cell (
			.clk, .x2(cx2[i]), .t(ct[i]), .side(co[i]),
			.x2_o(cx2[i+1]), .t_o(ct[i+1]), .side_o(co[i+1])
		);
	end

	logic [30:0] ps_s10, ps_s11;

	always_ff @(posedge clk) begin
		ps_s10 <= mulr_q30({1'b0, sx[3]}, st[3]);
		ps_s11 <= ps_s10;
	end

	logic [30:0] sv, cv, lim;
	trig_t       s_nx, c_nx;

	always_comb begin
		lim = {1'b0, thr, 15'd0};
		sv  = co[4].fold ? ct[4] : ps_s11;
		cv  = co[4].fold ? ps_s11 : ct[4];
		if (sv < lim) begin
			sv = '0;
		end
		if (cv < lim) begin
			cv = '0;
		end
		case (co[4].quad)
			2'd0: begin
				s_nx = '{neg: 1'b0, mag: sv};
				c_nx = '{neg: 1'b0, mag: cv};
			end
			2'd1: begin
				s_nx = '{neg: 1'b0, mag: cv};
				c_nx = '{neg: 1'b1, mag: sv};
			end
			2'd2: begin
				s_nx = '{neg: 1'b1, mag: sv};
				c_nx = '{neg: 1'b1, mag: cv};
			end
			default: begin
				s_nx = '{neg: 1'b1, mag: cv};
				c_nx = '{neg: 1'b0, mag: sv};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		sin_o <= s_nx;
		cos_o <= c_nx;
	end

endmodule

/* design/euler_to_quaternion.sv */
// Euler angles to quaternion. Takes one request per cycle while fewer than 32 are
// outstanding; each result runs through the pipeline: 12 stages of sine/cosine
// (phase fold, radian scale, square, a chain of Horner cells, quadrant and snap)
// and 5 stages of products, sums and output rounding. Results queue in a
// 32-entry output buffer, so requests keep flowing while the consumer stalls
// until 32 requests are outstanding. The snap threshold resets to 3.
module euler_to_quaternion import e2q_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int OUT_BITS   = 16
) (
	input logic          clk,
	input logic          arst_n,
	e2q_angle_if.sink    angles,
	e2q_quat_if.source   quat,
	e2q_cfg_if.sink      cfg
);

	localparam int SH     = 31 - OUT_BITS;
	localparam int R_SH   = (SH > 0) ? SH : 0;
	localparam int RND_SH = (SH > 0) ? SH - 1 : 0;
	localparam logic signed [34:0] MAXV = (35'sd1 <<< (OUT_BITS - 1)) - 35'sd1;
	localparam logic signed [34:0] MINV = -MAXV - 35'sd1;

	logic [14:0] thr_q;
	logic        acc_in, acc_out;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 15'd3;
		end else if (cfg.valid && cfg.ready) begin
			thr_q <= cfg.snap_threshold;
		end
	end

	trig_t sr, cr, sp, cp, sy, cy;

	e2q_sincos #(.ANGLE_BITS(ANGLE_BITS), .NEGATE(1'b0)) u_roll (
		.clk, .angle(angles.roll_angle), .thr(thr_q), .sin_o(sr), .cos_o(cr));
	e2q_sincos #(.ANGLE_BITS(ANGLE_BITS), .NEGATE(1'b1)) u_pitch (
		.clk, .angle(angles.pitch_angle), .thr(thr_q), .sin_o(sp), .cos_o(cp));
	e2q_sincos #(.ANGLE_BITS(ANGLE_BITS), .NEGATE(1'b0)) u_yaw (
		.clk, .angle(angles.yaw_angle), .thr(thr_q), .sin_o(sy), .cos_o(cy));

	// pair products: cr*cp, sr*sp, sr*cp, cr*sp
	logic [61:0] pa_s1, pb_s1, pc_s1, pd_s1;
	logic [3:0]  pn_s1, pn_s2;
	trig_t       cy_s1, sy_s1, cy_s2, sy_s2;
	logic [30:0] ma_s2, mb_s2, mc_s2, md_s2;
	logic [61:0] tp_s3 [8];
	logic [7:0]  tn_s3;
	logic signed [32:0] w_s4, x_s4, y_s4, z_s4;
	logic [OUT_BITS-1:0] w_s5, x_s5, y_s5, z_s5;
	logic signed [32:0] term [8];

	always_ff @(posedge clk) begin
		pa_s1 <= 62'(cr.mag) * 62'(cp.mag);
		pb_s1 <= 62'(sr.mag) * 62'(sp.mag);
		pc_s1 <= 62'(sr.mag) * 62'(cp.mag);
		pd_s1 <= 62'(cr.mag) * 62'(sp.mag);
		pn_s1 <= {cr.neg ^ sp.neg, sr.neg ^ cp.neg, sr.neg ^ sp.neg, cr.neg ^ cp.neg};
		cy_s1 <= cy;
		sy_s1 <= sy;

		ma_s2 <= rnd_q30(pa_s1);
		mb_s2 <= rnd_q30(pb_s1);
		mc_s2 <= rnd_q30(pc_s1);
		md_s2 <= rnd_q30(pd_s1);
		pn_s2 <= pn_s1;
		cy_s2 <= cy_s1;
		sy_s2 <= sy_s1;

		tp_s3[0] <= 62'(ma_s2) * 62'(cy_s2.mag);
		tp_s3[1] <= 62'(mb_s2) * 62'(sy_s2.mag);
		tp_s3[2] <= 62'(mc_s2) * 62'(cy_s2.mag);
		tp_s3[3] <= 62'(md_s2) * 62'(sy_s2.mag);
		tp_s3[4] <= 62'(md_s2) * 62'(cy_s2.mag);
		tp_s3[5] <= 62'(mc_s2) * 62'(sy_s2.mag);
		tp_s3[6] <= 62'(ma_s2) * 62'(sy_s2.mag);
		tp_s3[7] <= 62'(mb_s2) * 62'(cy_s2.mag);
		tn_s3 <= {pn_s2[1] ^ cy_s2.neg, pn_s2[0] ^ sy_s2.neg,
			pn_s2[2] ^ sy_s2.neg, pn_s2[3] ^ cy_s2.neg,
			pn_s2[3] ^ sy_s2.neg, pn_s2[2] ^ cy_s2.neg,
			pn_s2[1] ^ sy_s2.neg, pn_s2[0] ^ cy_s2.neg};
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			term[i] = tn_s3[i] ? -$signed({2'b00, rnd_q30(tp_s3[i])})
				: $signed({2'b00, rnd_q30(tp_s3[i])});
		end
	end

	function automatic logic [OUT_BITS-1:0] to_out(input logic signed [32:0] v);
		logic              neg;
		logic [32:0]       mag;
		logic [33:0]       rm;
		logic signed [34:0] r;
		neg = v[32];
		mag = neg ? 33'(-v) : 33'(v);
		if (SH > 0) begin
			rm = (34'(mag) + (34'd1 << RND_SH)) >> R_SH;
		end else if (SH == 0) begin
			rm = 34'(mag);
		end else begin
			rm = 34'(mag) << 1;
		end
		r = neg ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
		if (r > MAXV) begin
			r = MAXV;
		end else if (r < MINV) begin
			r = MINV;
		end
		return r[OUT_BITS-1:0];
	endfunction

	always_ff @(posedge clk) begin
		w_s4 <= term[0] + term[1];
		x_s4 <= term[2] - term[3];
		y_s4 <= term[4] + term[5];
		z_s4 <= term[6] - term[7];
		w_s5 <= to_out(w_s4);
		x_s5 <= to_out(x_s4);
		y_s5 <= to_out(y_s4);
		z_s5 <= to_out(z_s4);
	end

	// valid tracking and output buffer
	logic [LAT-1:0]        vld_q;
	logic [FIFO_AW:0]      count_q, wr_q, rd_q, fill;
	logic [4*OUT_BITS-1:0] mem_q [FIFO_DEPTH];

	assign angles.ready = count_q < (FIFO_AW + 1)'(FIFO_DEPTH);
	assign acc_in       = angles.valid && angles.ready;
	assign acc_out      = quat.valid && quat.ready;
	assign fill         = wr_q - rd_q;
	assign quat.valid   = wr_q != rd_q;
	assign {quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z} = mem_q[rd_q[FIFO_AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			count_q <= '0;
			wr_q    <= '0;
			rd_q    <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], acc_in};
			case ({acc_in, acc_out})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
			if (vld_q[LAT-1]) begin
				wr_q <= wr_q + 1'b1;
			end
			if (acc_out) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_q[LAT-1]) begin
			mem_q[wr_q[FIFO_AW-1:0]] <= {w_s5, x_s5, y_s5, z_s5};
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW + 1)'(FIFO_DEPTH))
		else $error("outstanding request count above buffer depth");
	a_fill_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= count_q)
		else $error("buffer holds more results than outstanding requests");
	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(vld_q) + fill) == count_q)
		else $error("in-flight plus buffered results differ from outstanding count");
	a_accept_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> vld_q[0])
		else $error("accepted request not tracked in pipeline");
`endif

endmodule
